>>> hw/rtl/eav_pkg.sv
// shared types and constants for the encoder accelerated value block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package eav_pkg;

  localparam int VALUE_W = 7;
  localparam int STEP_W  = 7;
  localparam int GAIN_W  = 16;
  localparam int TIME_W  = 32;
  localparam int DELTA_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [VALUE_W-1:0] LIMIT_SWITCH = VALUE_W'(2);
  localparam logic [VALUE_W-1:0] LIMIT_FULL   = VALUE_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_FLOOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_CAP   = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/eav_divider.sv
// serial restoring divider, one quotient bit per cycle
// depends on eav_pkg
`timescale 1ns / 1ps
`default_nettype none

module eav_divider
  import eav_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire div_ctrl_t         ctrl,
  input  wire logic [GAIN_W-1:0] dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output div_status_t            status,
  output logic [GAIN_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [GAIN_W-1:0] rem;
  logic [GAIN_W-1:0] quo;
  logic [TIME_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [GAIN_W:0]   trial;
  logic              fits;
  logic [GAIN_W:0]   diff;

  always_comb begin
    trial = {rem, quo[GAIN_W-1]};
    fits  = {{(TIME_W-GAIN_W-1){1'b0}}, trial} >= dvs;
    diff  = trial - dvs[GAIN_W:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(GAIN_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[GAIN_W-1:0] : trial[GAIN_W-1:0];
      quo <= {quo[GAIN_W-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = busy && (cnt == CNT_W'(1));
  assign quotient    = quo;

endmodule

`default_nettype wire

>>> hw/rtl/encoder_accelerated_value.sv
// top level of the encoder accelerated value block: sequencer, value store
// and last-move times; depends on eav_pkg and eav_divider
`timescale 1ns / 1ps
`default_nettype none

// One item is taken when the block is idle. An item with movement passes
// from transfer through the value store read, the serial divider that
// forms accel_gain / elapsed (one quotient bit a cycle), and the step and
// clamp state, then returns to idle, where the next item can be taken. An
// item with zero delta skips the divider. The result sits in an output
// register, so the next item is taken while it waits; a further result
// holds in the step and clamp state until that register is free. After
// reset the value store is cleared one entry a cycle, with no item taken;
// configuration writes are taken at any time.
module encoder_accelerated_value
  import eav_pkg::*;
#(
  parameter int ENCODERS    = 8,
  parameter int SECTIONS    = 8,
  parameter int CONTROLLERS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               encoder_number,
  input  wire logic [2:0]               section,
  input  wire logic [3:0]               controller,
  input  wire logic signed [DELTA_W-1:0] delta,
  input  wire logic [TIME_W-1:0]        now_ms,
  input  wire logic                     three_way,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [VALUE_W-1:0]            value,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [GAIN_W-1:0]        cfg_data
);

  localparam int SLOTS  = SECTIONS * CONTROLLERS;
  localparam int ENC_W  = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;
  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CTL_W  = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // index wrap tables
  logic [ENC_W-1:0] enc_map [8];
  logic [SEC_W-1:0] sec_map [8];
  logic [CTL_W-1:0] ctl_map [16];

  for (genvar i = 0; i < 8; i++) begin : g_enc_map
    assign enc_map[i] = ENC_W'(i % ENCODERS);
    assign sec_map[i] = SEC_W'(i % SECTIONS);
  end
  for (genvar i = 0; i < 16; i++) begin : g_ctl_map
    assign ctl_map[i] = CTL_W'(i % CONTROLLERS);
  end

  state_t state, state_next;

  logic [STEP_W-1:0] step_floor;
  logic [GAIN_W-1:0] accel_gain;
  logic [STEP_W-1:0] step_cap;

  logic [VALUE_W-1:0] store [SLOTS];
  logic [VALUE_W-1:0] rd_data;
  logic [SLOT_W-1:0]  clr_addr;

  logic [TIME_W-1:0] last_move [ENCODERS];

  logic [ENC_W-1:0]  enc;
  logic [SLOT_W-1:0] slot;
  logic              moving;
  logic              down;
  logic              three;
  logic [TIME_W-1:0] now;

  logic [SLOT_W-1:0] in_slot;
  logic              in_xfer;
  logic              out_free;
  logic [TIME_W-1:0] elapsed;

  div_ctrl_t         div_ctrl;
  div_status_t       div_status;
  logic [GAIN_W-1:0] quotient;

  logic [GAIN_W:0]        step_raw;
  logic [STEP_W-1:0]      step;
  logic signed [VALUE_W+1:0] sum;
  logic [VALUE_W-1:0]     lim;
  logic [VALUE_W-1:0]     result;

  logic store_we;
  logic load_out;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign in_slot   = SLOT_W'(sec_map[section]) * SLOT_W'(CONTROLLERS)
                     + SLOT_W'(ctl_map[controller]);
  assign elapsed   = now - last_move[enc];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == SLOT_W'(SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = moving ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall       = 1'b1;
    div_ctrl.start = 1'b0;
    store_we       = 1'b0;
    load_out       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_READ: begin
        div_ctrl.start = moving;
      end
      ST_FINISH: begin
        load_out = out_free;
        store_we = out_free && moving;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_floor <= STEP_W'(1);
      accel_gain <= '0;
      step_cap   <= STEP_W'(10);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP_FLOOR: step_floor <= cfg_data[STEP_W-1:0];
        CFG_ACCEL_GAIN: accel_gain <= cfg_data;
        CFG_STEP_CAP:   step_cap   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + SLOT_W'(1);
    end
  end

  // value store
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      store[clr_addr] <= '0;
    end else if (store_we) begin
      store[slot] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data <= store[in_slot];
    end
  end

  // item fields
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      enc    <= enc_map[encoder_number];
      slot   <= in_slot;
      moving <= (delta != '0);
      down   <= delta[DELTA_W-1];
      three  <= three_way;
      now    <= now_ms;
    end
  end

  // last-move times
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENCODERS; i++) begin
        last_move[i] <= '0;
      end
    end else if (state == ST_READ && moving) begin
      last_move[enc] <= now;
    end
  end

  eav_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (accel_gain),
    .divisor  ((elapsed == '0) ? TIME_W'(1) : elapsed),
    .status   (div_status),
    .quotient (quotient)
  );

  // step, move and clamp
  always_comb begin
    step_raw = {{(GAIN_W+1-STEP_W){1'b0}}, step_floor} + {1'b0, quotient};
    if (step_raw > {{(GAIN_W+1-STEP_W){1'b0}}, step_cap}) begin
      step = step_cap;
    end else begin
      step = step_raw[STEP_W-1:0];
    end
    if (down) begin
      sum = $signed({2'b00, rd_data}) - $signed({2'b00, step});
    end else begin
      sum = $signed({2'b00, rd_data}) + $signed({2'b00, step});
    end
    lim = three ? LIMIT_SWITCH : LIMIT_FULL;
    if (!moving) begin
      result = rd_data;
    end else if (sum < 0) begin
      result = '0;
    end else if (sum > $signed({2'b00, lim})) begin
      result = lim;
    end else begin
      result = sum[VALUE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value <= result;
    end
  end

endmodule

`default_nettype wire
